/* sv/assert_macros.svh */
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds at an edge, so cons holds at the same edge
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante holds at an edge, so cons holds at the next edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/bba_pkg.sv */
package bba_pkg;

  localparam int CMD_W    = 2;
  localparam int BLK_W    = 12;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_UNUSED  = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                used;
    logic [BLK_W-1:0]    result_block;
  } result_t;

endpackage

/* sv/bba_first_zero.sv */
module bba_first_zero #(
  parameter int WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0]         word,
  output logic                         full,
  output logic [WORD_BITS-1:0]         mask,
  output logic [$clog2(WORD_BITS)-1:0] index
);

  localparam int BW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] inv;

  assign inv  = ~word;
  assign full = ~|inv;
  assign mask = inv & (~inv + WORD_BITS'(1));

  always_comb begin
    index = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      for (int k = 0; k < BW; k++) begin
        if (((i >> k) & 1) == 1) begin
          index[k] = index[k] | mask[i];
        end
      end
    end
  end

endmodule

/* sv/bitmap_block_allocator.sv */
// Bitmap block allocator: first-fit allocation over a usage bitmap of
// NUM_BLOCKS blocks kept in an on-chip memory of WORD_BITS-bit words.
// Input channel s_*: one command per transfer (allocate, free, query).
// Output channel m_*: exactly one result per command, in command order.
// cfg_we/cfg_data write block_count; allocation returns only numbers below it.
// Free and query pass from input transfer to result valid through memory read,
// read-modify-write and output load. Allocate scans the bitmap one word per
// cycle through the memory read port, reading at most NUM_WORDS words (64 by
// default). One command is in flight at a time; s_tready is high only while
// the block is idle.
// Reset: the memory is swept one word per cycle over all NUM_WORDS words, block 0
// is marked used and all other blocks free; s_tready stays low meanwhile.
// Stall: a result waits in the output register while m_tready is low; the
// next command is still taken, and its result is held until the register
// frees up.
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int NUM_BLOCKS = 4096,
  parameter int WORD_BITS  = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_W-1:0]    s_tdata,   // cmd[1:0], block_number[13:2]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata    // result_block[11:0], used[12], status[14:13]
);

  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int CW = (AW + BW + 1 > COUNT_W) ? AW + BW + 1 : COUNT_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);
  localparam logic [CW-1:0] LIMIT = CW'(NUM_BLOCKS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [2:0]         state, state_next;
  logic [AW-1:0]      idx, idx_next;
  logic [COUNT_W-1:0] block_count;
  logic [CMD_W-1:0]   cmd_q;
  logic [BLK_W-1:0]   blk_q;
  result_t            res, res_next;
  logic               m_tvalid_next;
  logic [OUT_W-1:0]   m_tdata_next;

  logic [CMD_W-1:0] in_cmd;
  logic [BLK_W-1:0] in_blk;
  logic [CW-1:0]    in_blk_ext;
  logic [CW-1:0]    blk_ext;
  logic [BW-1:0]    blk_bit;
  logic             blk_in_range;
  logic             cur_bit;

  logic                 fz_full;
  logic [WORD_BITS-1:0] fz_mask;
  logic [BW-1:0]        fz_index;
  logic [CW-1:0]        cand;

  assign in_cmd       = s_tdata[CMD_W-1:0];
  assign in_blk       = s_tdata[CMD_W+BLK_W-1:CMD_W];
  assign in_blk_ext   = CW'(in_blk);
  assign blk_ext      = CW'(blk_q);
  assign blk_bit      = blk_ext[BW-1:0];
  assign blk_in_range = blk_ext < LIMIT;
  assign cur_bit      = rd_data[blk_bit];
  assign cand         = CW'({idx, fz_index});
  assign s_tready     = (state == S_IDLE);

  bba_first_zero #(
    .WORD_BITS(WORD_BITS)
  ) u_first_zero (
    .word  (rd_data),
    .full  (fz_full),
    .mask  (fz_mask),
    .index (fz_index)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    res_next      = res;
    rd_addr       = idx + AW'(1);
    wr_en         = 1'b0;
    wr_addr       = idx;
    wr_data       = rd_data;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next  = m_tdata;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = (idx == '0) ? WORD_BITS'(1) : '0;
        if (idx == LAST_WORD) begin
          state_next = S_IDLE;
        end
        idx_next = idx + AW'(1);
      end
      S_IDLE: begin
        idx_next = '0;
        rd_addr  = (in_cmd == CMD_ALLOC) ? '0 : AW'(in_blk_ext >> BW);
        if (s_tvalid) begin
          state_next = (in_cmd == CMD_ALLOC) ? S_SCAN : S_READ;
        end
      end
      S_READ: begin
        res_next   = '0;
        wr_addr    = AW'(blk_ext >> BW);
        wr_data    = rd_data & ~(WORD_BITS'(1) << blk_bit);
        state_next = S_DONE;
        unique case (cmd_q)
          CMD_FREE: begin
            if (blk_q == '0 || !blk_in_range || !cur_bit) begin
              res_next.status = STATUS_INVALID;
            end else begin
              wr_en = 1'b1;
            end
          end
          CMD_QUERY: begin
            res_next.used = blk_in_range && cur_bit;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        res_next = '0;
        if (!fz_full) begin
          state_next = S_DONE;
          if (cand < CW'(block_count) && cand < LIMIT) begin
            wr_en                 = 1'b1;
            wr_data               = rd_data | fz_mask;
            res_next.result_block = cand[BLK_W-1:0];
          end else begin
            res_next.status = STATUS_FULL;
          end
        end else if (idx == LAST_WORD) begin
          state_next      = S_DONE;
          res_next.status = STATUS_FULL;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = OUT_W'(res);
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      idx         <= '0;
      block_count <= COUNT_RESET;
      m_tvalid    <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      m_tvalid <= m_tvalid_next;
      if (cfg_we) begin
        block_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    res     <= res_next;
    m_tdata <= m_tdata_next;
    if (s_tvalid && s_tready) begin
      cmd_q <= in_cmd;
      blk_q <= in_blk;
    end
  end

endmodule

/* sv/bba_checker.sv */
`include "assert_macros.svh"

module bba_checker import bba_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic [STATUS_W-1:0] status;
  logic                used;
  logic [BLK_W-1:0]    result_block;

  assign status       = m_tdata[BLK_W+STATUS_W:BLK_W+1];
  assign used         = m_tdata[BLK_W];
  assign result_block = m_tdata[BLK_W-1:0];

  `ASSERT_SAME(a_status_code, clk, rst, m_tvalid, status != STATUS_UNUSED, "bad status code")
  `ASSERT_SAME(a_fail_zero, clk, rst, m_tvalid && status != STATUS_OK, result_block == '0 && !used, "failed command returned data")
  `ASSERT_SAME(a_used_only, clk, rst, m_tvalid && used, result_block == '0, "query result carries a block number")
  `ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready, "second command taken while busy")
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
